// ===== design/psrmc_pkg.sv =====
`timescale 1ns / 1ps
package psrmc_pkg;

    localparam int FLOWS_PER_FAMILY_DEF = 8;
    localparam int HISTORY_DEPTH_DEF    = 4096;
    localparam int MAX_BANDS_DEF        = 4;
    localparam int THRESH_REGS          = 4;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    localparam logic [2:0]  BAND_COUNT_RST = 3'd3;
    localparam logic [31:0] THR0_RST       = 32'd12500;
    localparam logic [31:0] THR1_RST       = 32'd125000;
    localparam logic [31:0] THR2_RST       = 32'd125000000;
    localparam logic [31:0] THR3_RST       = 32'hFFFF_FFFF;
    localparam logic [11:0] INTERVAL_RST   = 12'd60;

    localparam logic [1:0] CMD_CLASSIFY = 2'd0;
    localparam logic [1:0] CMD_RECORD   = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;
    localparam logic [1:0] CMD_NONE     = 2'd3;

    localparam logic [1:0] FAM_IPV4  = 2'd0;
    localparam logic [1:0] FAM_IPV6  = 2'd1;
    localparam logic [1:0] FAM_OTHER = 2'd2;
    localparam logic [1:0] FAM_RESV  = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NOTIP = 2'd2;

    localparam logic [2:0] CFG_BAND_COUNT = 3'd0;
    localparam logic [2:0] CFG_THR0       = 3'd1;
    localparam logic [2:0] CFG_THR1       = 3'd2;
    localparam logic [2:0] CFG_THR2       = 3'd3;
    localparam logic [2:0] CFG_THR3       = 3'd4;
    localparam logic [2:0] CFG_INTERVAL   = 3'd5;

    typedef struct packed {
        logic latch;
        logic srch;
        logic append;
        logic full;
        logic classify;
        logic tick_init;
        logic ent_load;
        logic rd;
        logic ev;
        logic div_start;
        logic div_step;
        logic wr_rate;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic       is_ip;
        logic       hit;
        logic       srch_last;
        logic       n_zero;
        logic       ev_stop;
        logic       div_last;
        logic       ent_last;
    } t_sts;

endpackage

// ===== design/psrmc_ctrl.sv =====
`timescale 1ns / 1ps
module psrmc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  psrmc_pkg::t_sts i_sts,
    output psrmc_pkg::t_cmd o_cmd
);
    import psrmc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_SRCH  = 4'd2;
    localparam logic [3:0] S_APP   = 4'd3;
    localparam logic [3:0] S_CLASS = 4'd4;
    localparam logic [3:0] S_TINIT = 4'd5;
    localparam logic [3:0] S_TENT  = 4'd6;
    localparam logic [3:0] S_TRD   = 4'd7;
    localparam logic [3:0] S_TEV   = 4'd8;
    localparam logic [3:0] S_DIV0  = 4'd9;
    localparam logic [3:0] S_DIV   = 4'd10;
    localparam logic [3:0] S_TWR   = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    t_cmd       cmd;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.latch = 1'b1;
                    n_state   = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.command == CMD_TICK) begin
                    n_state = S_TINIT;
                end else if ((i_sts.command == CMD_CLASSIFY || i_sts.command == CMD_RECORD)
                             && i_sts.is_ip) begin
                    n_state = S_SRCH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SRCH: begin
                cmd.srch = 1'b1;
                if (i_sts.hit) begin
                    n_state = (i_sts.command == CMD_RECORD) ? S_APP : S_CLASS;
                end else if (i_sts.srch_last) begin
                    if (i_sts.command == CMD_RECORD) begin
                        cmd.full = 1'b1;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_CLASS;
                    end
                end
            end
            S_APP: begin
                cmd.append = 1'b1;
                n_state    = S_DONE;
            end
            S_CLASS: begin
                cmd.classify = 1'b1;
                n_state      = S_DONE;
            end
            S_TINIT: begin
                cmd.tick_init = 1'b1;
                n_state       = S_TENT;
            end
            S_TENT: begin
                cmd.ent_load = 1'b1;
                n_state      = S_TRD;
            end
            S_TRD: begin
                if (i_sts.n_zero) begin
                    n_state = S_DIV0;
                end else begin
                    cmd.rd  = 1'b1;
                    n_state = S_TEV;
                end
            end
            S_TEV: begin
                cmd.ev  = 1'b1;
                n_state = i_sts.ev_stop ? S_DIV0 : S_TRD;
            end
            S_DIV0: begin
                cmd.div_start = 1'b1;
                n_state       = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_TWR;
            end
            S_TWR: begin
                cmd.wr_rate = 1'b1;
                n_state     = i_sts.ent_last ? S_DONE : S_TENT;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) n_out_valid = 1'b0;
        if (cmd.load_out) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== design/psrmc_dp.sv =====
`timescale 1ns / 1ps
module psrmc_dp #(
    parameter int FLOWS_PER_FAMILY = psrmc_pkg::FLOWS_PER_FAMILY_DEF,
    parameter int HISTORY_DEPTH    = psrmc_pkg::HISTORY_DEPTH_DEF,
    parameter int MAX_BANDS        = psrmc_pkg::MAX_BANDS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data,
    input  logic [1:0]      i_command,
    input  logic [1:0]      i_family,
    input  logic [63:0]     i_addr_high,
    input  logic [63:0]     i_addr_low,
    input  logic [15:0]     i_packet_bytes,
    input  logic [63:0]     i_now_ns,
    input  psrmc_pkg::t_cmd i_cmd,
    output psrmc_pkg::t_sts o_sts,
    output logic [1:0]      o_band,
    output logic [31:0]     o_flow_rate,
    output logic [1:0]      o_status
);
    import psrmc_pkg::*;

    localparam int E   = 2 * FLOWS_PER_FAMILY;
    localparam int EW  = $clog2(E);
    localparam int IW  = (FLOWS_PER_FAMILY > 1) ? $clog2(FLOWS_PER_FAMILY) : 1;
    localparam int HW  = $clog2(HISTORY_DEPTH);
    localparam int FW  = $clog2(HISTORY_DEPTH + 1);
    localparam int AW  = $clog2(E * HISTORY_DEPTH);
    localparam int SW  = FW + 16;
    localparam int CW  = $clog2(SW);
    localparam int QW  = (SW > 32) ? SW : 32;
    localparam int LIM = (MAX_BANDS < THRESH_REGS) ? MAX_BANDS : THRESH_REGS;

    // configuration
    logic [2:0]  r_band_count;
    logic [31:0] r_thr [THRESH_REGS];
    logic [11:0] r_interval;

    // latched item
    logic [1:0]   r_cmd;
    logic         r_ip;
    logic         r_v6;
    logic [127:0] r_skey;
    logic [15:0]  r_size;
    logic [63:0]  r_now;

    // flow table and per-entry state
    logic [127:0]  r_key   [E];
    logic [HW-1:0] r_head  [E];
    logic [FW-1:0] r_fill  [E];
    logic [31:0]   r_rates [E];

    // history memory
    logic [15:0] r_mem_size [E * HISTORY_DEPTH];
    logic [63:0] r_mem_time [E * HISTORY_DEPTH];
    logic [15:0] r_rd_size;
    logic [63:0] r_rd_time;

    logic [IW-1:0] r_idx;
    logic [EW-1:0] r_ent;
    logic [HW-1:0] r_pos;
    logic [FW-1:0] r_n;
    logic [63:0]   r_window;
    logic [11:0]   r_secs;
    logic [SW-1:0] r_sum;
    logic [SW-1:0] r_q;
    logic [11:0]   r_rem;
    logic [CW-1:0] r_cnt;

    logic [31:0] r_rate;
    logic [1:0]  r_band;
    logic [1:0]  r_stat;
    logic [1:0]  r_o_band;
    logic [31:0] r_o_rate;
    logic [1:0]  r_o_stat;

    logic [EW-1:0] e_cur;
    logic          hit;
    logic [HW-1:0] pos_prev;
    logic [AW-1:0] app_addr;
    logic [AW-1:0] rd_addr;
    logic          ev_stop;
    logic [12:0]   rem_try;
    logic [2:0]    nb;
    logic [1:0]    band_sel;
    logic [QW-1:0] q_ext;
    logic [31:0]   q_sat;
    logic [11:0]   secs_eff;

    assign e_cur = r_v6 ? (EW'(FLOWS_PER_FAMILY) + EW'(r_idx)) : EW'(r_idx);
    assign hit   = (r_key[e_cur] == r_skey) || ((r_cmd == CMD_RECORD) && (r_key[e_cur] == '0));

    assign pos_prev = (r_pos == '0) ? HW'(HISTORY_DEPTH - 1) : r_pos - HW'(1);
    assign app_addr = AW'(e_cur) * AW'(HISTORY_DEPTH) + AW'(r_head[e_cur]);
    assign rd_addr  = AW'(r_ent) * AW'(HISTORY_DEPTH) + AW'(pos_prev);

    assign ev_stop = (r_rd_time > r_now) || ((r_now - r_rd_time) > r_window);

    assign rem_try  = {r_rem, r_q[SW-1]};
    assign secs_eff = (r_interval == '0) ? 12'd1 : r_interval;
    assign q_ext    = QW'(r_q);
    assign q_sat    = (q_ext > QW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : q_ext[31:0];

    always_comb begin
        if (r_band_count == '0) nb = 3'd1;
        else if (r_band_count > 3'(LIM)) nb = 3'(LIM);
        else nb = r_band_count;
        band_sel = 2'(nb - 3'd1);
        for (int p = LIM - 1; p >= 0; p--) begin
            if ((3'(p) < nb) && (r_rate < r_thr[p])) band_sel = 2'(p);
        end
    end

    assign o_sts.command   = r_cmd;
    assign o_sts.is_ip     = r_ip;
    assign o_sts.hit       = hit;
    assign o_sts.srch_last = (r_idx == IW'(FLOWS_PER_FAMILY - 1));
    assign o_sts.n_zero    = (r_n == '0);
    assign o_sts.ev_stop   = ev_stop;
    assign o_sts.div_last  = (r_cnt == CW'(SW - 1));
    assign o_sts.ent_last  = (r_ent == EW'(E - 1));

    assign o_band      = r_o_band;
    assign o_flow_rate = r_o_rate;
    assign o_status    = r_o_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_count <= BAND_COUNT_RST;
            r_thr[0]     <= THR0_RST;
            r_thr[1]     <= THR1_RST;
            r_thr[2]     <= THR2_RST;
            r_thr[3]     <= THR3_RST;
            r_interval   <= INTERVAL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BAND_COUNT: r_band_count <= i_cfg_data[2:0];
                CFG_THR0:       r_thr[0]     <= i_cfg_data;
                CFG_THR1:       r_thr[1]     <= i_cfg_data;
                CFG_THR2:       r_thr[2]     <= i_cfg_data;
                CFG_THR3:       r_thr[3]     <= i_cfg_data;
                CFG_INTERVAL:   r_interval   <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < E; k++) begin
                r_key[k]   <= '0;
                r_head[k]  <= '0;
                r_fill[k]  <= '0;
                r_rates[k] <= '0;
            end
        end else begin
            if (i_cmd.append) begin
                r_key[e_cur]  <= r_skey;
                r_head[e_cur] <= (r_head[e_cur] == HW'(HISTORY_DEPTH - 1)) ? '0
                                 : r_head[e_cur] + HW'(1);
                if (r_fill[e_cur] < FW'(HISTORY_DEPTH)) r_fill[e_cur] <= r_fill[e_cur] + FW'(1);
            end
            if (i_cmd.wr_rate) r_rates[r_ent] <= q_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_mem_size[app_addr] <= r_size;
            r_mem_time[app_addr] <= r_now;
        end
        if (i_cmd.rd) begin
            r_rd_size <= r_mem_size[rd_addr];
            r_rd_time <= r_mem_time[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd  <= i_command;
            r_ip   <= (i_family == FAM_IPV4) || (i_family == FAM_IPV6);
            r_v6   <= (i_family == FAM_IPV6);
            r_skey <= (i_family == FAM_IPV6) ? {i_addr_high, i_addr_low}
                                             : {96'd0, i_addr_low[31:0]};
            r_size <= i_packet_bytes;
            r_now  <= i_now_ns;
            r_idx  <= '0;
            r_rate <= '0;
            r_band <= '0;
            r_stat <= (((i_command == CMD_CLASSIFY) || (i_command == CMD_RECORD))
                       && !((i_family == FAM_IPV4) || (i_family == FAM_IPV6)))
                      ? ST_NOTIP : ST_DONE;
        end
        if (i_cmd.srch) begin
            if (hit) begin
                if (r_cmd == CMD_CLASSIFY) r_rate <= r_rates[e_cur];
            end else begin
                r_idx <= r_idx + IW'(1);
            end
        end
        if (i_cmd.full) r_stat <= ST_FULL;
        if (i_cmd.classify) r_band <= band_sel;
        if (i_cmd.tick_init) begin
            r_ent    <= '0;
            r_secs   <= secs_eff;
            r_window <= 64'(secs_eff * NS_PER_SEC);
        end
        if (i_cmd.ent_load) begin
            r_pos <= r_head[r_ent];
            r_n   <= r_fill[r_ent];
            r_sum <= '0;
        end
        if (i_cmd.rd) begin
            r_pos <= pos_prev;
            r_n   <= r_n - FW'(1);
        end
        if (i_cmd.ev && !ev_stop) r_sum <= r_sum + SW'(r_rd_size);
        // restoring division of the window sum by the interval, one bit a cycle
        if (i_cmd.div_start) begin
            r_q   <= r_sum;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            if (rem_try >= {1'b0, r_secs}) begin
                r_rem <= 12'(rem_try - {1'b0, r_secs});
                r_q   <= {r_q[SW-2:0], 1'b1};
            end else begin
                r_rem <= rem_try[11:0];
                r_q   <= {r_q[SW-2:0], 1'b0};
            end
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.wr_rate) r_ent <= r_ent + EW'(1);
        if (i_cmd.load_out) begin
            r_o_band <= r_band;
            r_o_rate <= r_rate;
            r_o_stat <= r_stat;
        end
    end

endmodule

// ===== design/per_source_rate_meter_classifier_top.sv =====
`timescale 1ns / 1ps
// Classify and record search the entries of the item's family in order up to the first hit;
// a record that finds no matching or empty entry sets status full. Tick walks each entry,
// reading ring records newest first until the ring runs out or a record leaves the window,
// then divides the sum by the interval. One item in flight; the next is taken from the cycle
// after its result is loaded, while that result waits in the output register.
// Sync active-low reset clears flow table, rings, rates, loads defaults; history not cleared.
module per_source_rate_meter_classifier_top #(
    parameter int FLOWS_PER_FAMILY = psrmc_pkg::FLOWS_PER_FAMILY_DEF,
    parameter int HISTORY_DEPTH    = psrmc_pkg::HISTORY_DEPTH_DEF,
    parameter int MAX_BANDS        = psrmc_pkg::MAX_BANDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [1:0]  i_family,
    input  logic [63:0] i_addr_high,
    input  logic [63:0] i_addr_low,
    input  logic [15:0] i_packet_bytes,
    input  logic [63:0] i_now_ns,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_band,
    output logic [31:0] o_flow_rate,
    output logic [1:0]  o_status
);
    import psrmc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    psrmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    psrmc_dp #(
        .FLOWS_PER_FAMILY (FLOWS_PER_FAMILY),
        .HISTORY_DEPTH    (HISTORY_DEPTH),
        .MAX_BANDS        (MAX_BANDS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_family       (i_family),
        .i_addr_high    (i_addr_high),
        .i_addr_low     (i_addr_low),
        .i_packet_bytes (i_packet_bytes),
        .i_now_ns       (i_now_ns),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_band         (o_band),
        .o_flow_rate    (o_flow_rate),
        .o_status       (o_status)
    );

endmodule
